>>> hw/rtl/qsg_pkg.sv
// shared types and constants for the quartic spline field gather
`default_nettype none
package qsg_pkg;

	localparam int NUM_FIELDS = 6;
	localparam int NUM_TAPS   = 5;
	localparam int FRAC       = 24;
	localparam int WW         = 25;
	localparam int TW         = 26;

	// register indexes of the configuration port
	localparam logic CFG_INV_CELL_LENGTH   = 1'b0;
	localparam logic CFG_DOMAIN_START_CELL = 1'b1;

	localparam logic [23:0] INV_CELL_LENGTH_RST = 24'd65536;

	// field codes, bit set for fields that sit on the dual grid
	localparam logic [2:0] COMP_EX = 3'd0;
	localparam logic [2:0] COMP_EY = 3'd1;
	localparam logic [2:0] COMP_EZ = 3'd2;
	localparam logic [2:0] COMP_BX = 3'd3;
	localparam logic [2:0] COMP_BY = 3'd4;
	localparam logic [2:0] COMP_BZ = 3'd5;
	localparam logic [NUM_FIELDS-1:0] FIELD_DUAL = 6'b110001;

	localparam logic [47:0] HALF_Q48 = 48'd8388608;
	localparam logic signed [35:0] ONE_S = 36'sd16777216;
	localparam logic signed [35:0] WT_ROUND = 36'sd192;
	// floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2**27
	localparam logic [26:0] DIV3_MUL = 27'd89478486;
	localparam int DIV3_SHIFT = 28;

	typedef logic [NUM_TAPS-1:0][WW-1:0] w_arr_t;
	typedef logic [NUM_TAPS-1:0][31:0]   tap_arr_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} wt_en_t;

	typedef struct packed {
		logic s8;
		logic s9;
		logic s10;
	} ga_en_t;

endpackage
`default_nettype wire

>>> hw/rtl/qsg_mem.sv
// one field store copy: one write port, one registered read port
`default_nettype none
module qsg_mem #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [31:0]              wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [31:0]              rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/qsg_weights.sv
// five quartic b-spline weights from a signed distance, stages s3 to s7
`default_nettype none
module qsg_weights import qsg_pkg::*; (
	input  wire logic               clk,
	input  wire wt_en_t             en,
	input  wire logic signed [24:0] d_in,
	output w_arr_t                  w
);

	logic signed [24:0] d_s3, d_s4, d_s5;
	logic [23:0] a_s3, a_s4;
	logic [23:0] a2_s3, a2_s4, a2_s5;
	logic [23:0] a3_s4, a3_s5;
	logic [23:0] a4_s5;
	logic [NUM_TAPS-1:0][TW-1:0] t_s6;
	w_arr_t w_s7;

	logic [23:0] a_in;
	logic [47:0] p2, p3, p4;
	logic signed [35:0] dx, d3x, a2x, a4x;
	logic signed [35:0] s_sum [NUM_TAPS];
	logic signed [35:0] s_rnd [NUM_TAPS];
	logic [TW+26:0] q3 [NUM_TAPS];

	always_comb begin
		a_in = d_in[24] ? 24'(-d_in) : d_in[23:0];
		p2 = 48'(a_in) * 48'(a_in) + HALF_Q48;
		p3 = 48'(a2_s3) * 48'(a_s3) + HALF_Q48;
		p4 = 48'(a3_s4) * 48'(a_s4) + HALF_Q48;
	end

	always_comb begin
		dx  = 36'(d_s5);
		d3x = d_s5[24] ? -$signed({12'b0, a3_s5}) : $signed({12'b0, a3_s5});
		a2x = $signed({12'b0, a2_s5});
		a4x = $signed({12'b0, a4_s5});
		s_sum[0] = ONE_S - 36'sd8 * dx + 36'sd24 * a2x - 36'sd32 * d3x + 36'sd16 * a4x;
		s_sum[1] = 36'sd76 * ONE_S - 36'sd176 * dx + 36'sd96 * a2x + 36'sd64 * d3x
			- 36'sd64 * a4x;
		s_sum[2] = 36'sd230 * ONE_S - 36'sd240 * a2x + 36'sd96 * a4x;
		s_sum[3] = 36'sd76 * ONE_S + 36'sd176 * dx + 36'sd96 * a2x - 36'sd64 * d3x
			- 36'sd64 * a4x;
		s_sum[4] = ONE_S + 36'sd8 * dx + 36'sd24 * a2x + 36'sd32 * d3x + 36'sd16 * a4x;
		for (int k = 0; k < NUM_TAPS; k++) begin
			s_rnd[k] = s_sum[k] + WT_ROUND;
			q3[k] = (TW + 27)'(t_s6[k]) * (TW + 27)'(DIV3_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			d_s3  <= d_in;
			a_s3  <= a_in;
			a2_s3 <= p2[47:24];
		end
		if (en.s4) begin
			d_s4  <= d_s3;
			a_s4  <= a_s3;
			a2_s4 <= a2_s3;
			a3_s4 <= p3[47:24];
		end
		if (en.s5) begin
			d_s5  <= d_s4;
			a2_s5 <= a2_s4;
			a3_s5 <= a3_s4;
			a4_s5 <= p4[47:24];
		end
		if (en.s6) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				t_s6[k] <= s_sum[k][35] ? '0 : s_rnd[k][TW+6:7];
			end
		end
		if (en.s7) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				w_s7[k] <= q3[k][DIV3_SHIFT+WW-1:DIV3_SHIFT];
			end
		end
	end

	assign w = w_s7;

endmodule
`default_nettype wire

>>> hw/rtl/qsg_gather.sv
// five-tap weighted sum with rounding and saturation, stages s8 to s10
`default_nettype none
module qsg_gather import qsg_pkg::*; (
	input  wire logic     clk,
	input  wire ga_en_t   en,
	input  wire w_arr_t   w,
	input  wire tap_arr_t f,
	output logic [31:0]   q
);

	logic signed [57:0] p_s8 [NUM_TAPS];
	logic signed [60:0] acc_s9;
	logic [31:0] q_s10;

	logic signed [60:0] acc_sum;
	logic signed [60:0] acc_rnd;
	logic signed [36:0] r;
	logic [31:0] sat;

	always_comb begin
		acc_sum = '0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			acc_sum = acc_sum + 61'(p_s8[k]);
		end
		acc_rnd = acc_s9 + 61'sd8388608;
		r = acc_rnd[60:24];
		if (r > 37'sd2147483647) begin
			sat = 32'h7fff_ffff;
		end else if (r < -37'sd2147483648) begin
			sat = 32'h8000_0000;
		end else begin
			sat = r[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s8) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				p_s8[k] <= $signed({1'b0, w[k]}) * $signed(f[k]);
			end
		end
		if (en.s9) begin
			acc_s9 <= acc_sum;
		end
		if (en.s10) begin
			q_s10 <= sat;
		end
	end

	assign q = q_s10;

endmodule
`default_nettype wire

>>> hw/rtl/quartic_spline_field_gather_1d.sv
// top level: quartic b-spline field gather over six stored field arrays
// ten register stages, s1 to s10, between the input transaction and the result
// one transaction per cycle unless m_tready stalls, field writes and particles mixed
// each store is held in five copies, one per tap, so all taps read in the same cycle
// reset clears valid bits and dsc_q and sets inv_q to 65536; stores are not cleared
`default_nettype none
module quartic_spline_field_gather_1d import qsg_pkg::*; #(
	parameter int FIELD_CELLS = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// component, cell_index, field_value, particle_position
	input  wire logic [79:0]  s_tdata,
	// mode
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// e_x, e_y, e_z, b_x, b_y, b_z
	output logic      [191:0] m_tdata,
	// out_of_range
	output logic              m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [23:0]  cfg_data
);

	localparam int AW = $clog2(FIELD_CELLS);

	typedef struct packed {
		logic          mode;
		logic [2:0]    comp;
		logic [9:0]    cidx;
		logic [31:0]   value;
		logic [AW-1:0] lpb;
		logic [AW-1:0] ldb;
		logic          oor;
	} ctl_t;

	logic [23:0] inv_q;
	logic [15:0] dsc_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10;

	logic        mode_s1;
	logic [2:0]  comp_s1;
	logic [9:0]  cell_s1;
	logic [31:0] value_s1;
	logic [47:0] xc_s1;
	ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [24:0] dp_s2, dd_s2;
	logic mode_s7, oor_s7, oor_s8, oor_s9, oor_s10;

	logic [55:0] prod;
	logic [24:0] pn, dn;
	logic signed [26:0] lp, ld, lpm2, ldm2;
	logic lp_ok, ld_ok, cell_ok;

	wt_en_t wen;
	ga_en_t gen;
	w_arr_t wp, wd;
	tap_arr_t rd [NUM_FIELDS];
	logic [NUM_FIELDS-1:0][31:0] q;

	// handshake chain
	always_comb begin
		en_s10 = !vld_s10 || m_tready;
		en_s9  = !vld_s9 || en_s10;
		en_s8  = !vld_s8 || en_s9;
		en_s7  = !vld_s7 || en_s8;
		en_s6  = !vld_s6 || en_s7;
		en_s5  = !vld_s5 || en_s6;
		en_s4  = !vld_s4 || en_s5;
		en_s3  = !vld_s3 || en_s4;
		en_s2  = !vld_s2 || en_s3;
		en_s1  = !vld_s1 || en_s2;
		wen = '{s3: en_s3, s4: en_s4, s5: en_s5, s6: en_s6, s7: en_s7};
		gen = '{s8: en_s8, s9: en_s9, s10: en_s10};
	end

	assign s_tready  = en_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_CELL_LENGTH_RST;
			dsc_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INV_CELL_LENGTH:   inv_q <= cfg_data;
				CFG_DOMAIN_START_CELL: dsc_q <= cfg_data[15:0];
				default:               inv_q <= inv_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0;
		end else begin
			if (en_s1)  vld_s1  <= s_tvalid;
			if (en_s2)  vld_s2  <= vld_s1;
			if (en_s3)  vld_s3  <= vld_s2;
			if (en_s4)  vld_s4  <= vld_s3;
			if (en_s5)  vld_s5  <= vld_s4;
			if (en_s6)  vld_s6  <= vld_s5;
			if (en_s7)  vld_s7  <= vld_s6;
			// field writes end here, only particles go on
			if (en_s8)  vld_s8  <= vld_s7 && mode_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
		end
	end

	// node search and store range check
	always_comb begin
		prod = 56'(s_tdata[76:45]) * 56'(inv_q);
		pn   = {1'b0, xc_s1[47:24]} + 25'(xc_s1[23]);
		dn   = {1'b0, xc_s1[47:24]} + 25'd1;
		lp   = $signed({2'b0, pn}) - $signed({11'b0, dsc_q});
		ld   = $signed({2'b0, dn}) - $signed({11'b0, dsc_q});
		lpm2 = lp - 27'sd2;
		ldm2 = ld - 27'sd2;
		lp_ok = (lp >= 27'sd2) && (lp <= $signed(27'(FIELD_CELLS - 3)));
		ld_ok = (ld >= 27'sd2) && (ld <= $signed(27'(FIELD_CELLS - 3)));
		cell_ok = 32'(ctl_s6.cidx) < 32'(FIELD_CELLS);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1  <= s_tuser;
			comp_s1  <= s_tdata[2:0];
			cell_s1  <= s_tdata[12:3];
			value_s1 <= s_tdata[44:13];
			xc_s1    <= prod[55:8];
		end
		if (en_s2) begin
			ctl_s2.mode  <= mode_s1;
			ctl_s2.comp  <= comp_s1;
			ctl_s2.cidx  <= cell_s1;
			ctl_s2.value <= value_s1;
			ctl_s2.lpb   <= lpm2[AW-1:0];
			ctl_s2.ldb   <= ldm2[AW-1:0];
			ctl_s2.oor   <= !(lp_ok && ld_ok);
			dp_s2        <= 25'($signed(xc_s1[23:0]));
			dd_s2        <= $signed({1'b0, xc_s1[23:0]}) - 25'sd8388608;
		end
		if (en_s3) ctl_s3 <= ctl_s2;
		if (en_s4) ctl_s4 <= ctl_s3;
		if (en_s5) ctl_s5 <= ctl_s4;
		if (en_s6) ctl_s6 <= ctl_s5;
		if (en_s7) begin
			mode_s7 <= ctl_s6.mode;
			oor_s7  <= ctl_s6.oor;
		end
		if (en_s8)  oor_s8  <= oor_s7;
		if (en_s9)  oor_s9  <= oor_s8;
		if (en_s10) oor_s10 <= oor_s9;
	end

	qsg_weights u_wt_primal (
		.clk  (clk),
		.en   (wen),
		.d_in (dp_s2),
		.w    (wp)
	);

	qsg_weights u_wt_dual (
		.clk  (clk),
		.en   (wen),
		.d_in (dd_s2),
		.w    (wd)
	);

	for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_field
		logic [AW-1:0] base;
		logic          we;
		logic          re;

		assign base = FIELD_DUAL[f] ? ctl_s6.ldb : ctl_s6.lpb;
		assign we   = en_s7 && vld_s6 && !ctl_s6.mode && (ctl_s6.comp == 3'(f)) && cell_ok;
		assign re   = en_s7 && vld_s6 && ctl_s6.mode;

		for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
			qsg_mem #(
				.DEPTH (FIELD_CELLS)
			) u_mem (
				.clk   (clk),
				.we    (we),
				.waddr (AW'(ctl_s6.cidx)),
				.wdata (ctl_s6.value),
				.re    (re),
				.raddr (base + AW'(k)),
				.rdata (rd[f][k])
			);
		end

		qsg_gather u_gather (
			.clk (clk),
			.en  (gen),
			.w   (FIELD_DUAL[f] ? wd : wp),
			.f   (rd[f]),
			.q   (q[f])
		);

		assign m_tdata[32*f +: 32] = oor_s10 ? 32'd0 : q[f];
	end

	assign m_tvalid = vld_s10;
	assign m_tuser  = oor_s10;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out of range result carries nonzero fields");

	a_ready_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_s1 && vld_s2 && vld_s10)
		else $error("input stalled while pipeline has a bubble");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		en_s8 && vld_s7 && !mode_s7 |=> !vld_s8)
		else $error("field write produced a result");

endmodule
`default_nettype wire
